FILE: design/ropd_pkg.sv
// Shared types, codes and helper functions of the rectangle overlap pair detector.
package ropd_pkg;

   // Table size default and fixed field widths.
   localparam int DEF_SLOTS  = 8;
   localparam int IDX_W      = 3;
   localparam int KIND_COUNT = 5;
   localparam int MASK_W     = KIND_COUNT * KIND_COUNT;

   // Operation codes of a request transaction.
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_MARK   = 3'd1;
   localparam logic [2:0] OP_SETACT = 3'd2;
   localparam logic [2:0] OP_SCAN   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // Result kind codes of a response transaction.
   localparam logic [2:0] RK_ADDED = 3'd0;
   localparam logic [2:0] RK_FULL  = 3'd1;
   localparam logic [2:0] RK_ACK   = 3'd2;
   localparam logic [2:0] RK_PAIR  = 3'd3;
   localparam logic [2:0] RK_DONE  = 3'd4;

   // One request transaction.
   typedef struct packed {
      logic [2:0]         operation;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [14:0]        rect_w;
      logic [14:0]        rect_h;
      logic [2:0]         kind;
      logic               has_listener;
      logic               active_flag;
      logic [2:0]         slot;
   } item_type;

   // One slot table entry: edges are kept with the far edges precomputed.
   typedef struct packed {
      logic signed [15:0] x0;
      logic signed [15:0] y0;
      logic signed [16:0] x1;
      logic signed [16:0] y1;
      logic               empty;
      logic [2:0]         kind;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             exec;
      logic             purge;
      logic             rd_en;
      logic [IDX_W-1:0] rd_a;
      logic [IDX_W-1:0] rd_b;
      logic [IDX_W-1:0] ev_a;
      logic [IDX_W-1:0] ev_b;
      logic             emit_pair;
      logic             emit_done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic pair_hit;
   } sts_type;

   // Builds a table entry from the add fields of a request.
   function automatic entry_type make_entry(item_type it);
      entry_type e;
      e.x0    = it.rect_x;
      e.y0    = it.rect_y;
      e.x1    = 17'({it.rect_x[15], it.rect_x}) + 17'({2'b00, it.rect_w});
      e.y1    = 17'({it.rect_y[15], it.rect_y}) + 17'({2'b00, it.rect_h});
      e.empty = (it.rect_w == 15'd0) || (it.rect_h == 15'd0);
      e.kind  = it.kind;
      return e;
   endfunction

   // Strict overlap of two entries; touching edges do not count.
   function automatic logic entries_overlap(entry_type a, entry_type b);
      logic sx, sy;
      sx = ($signed({a.x0[15], a.x0}) < $signed(b.x1)) &&
           ($signed({b.x0[15], b.x0}) < $signed(a.x1));
      sy = ($signed({a.y0[15], a.y0}) < $signed(b.y1)) &&
           ($signed({b.y0[15], b.y0}) < $signed(a.y1));
      return !a.empty && !b.empty && sx && sy;
   endfunction

   // Looks up whether kind self is notified on touching kind other.
   function automatic logic kind_allows(logic [MASK_W-1:0] mask, logic [2:0] self,
                                        logic [2:0] other);
      logic [4:0] idx;
      idx = 5'(self) * 5'(KIND_COUNT) + 5'(other);
      if ((self >= 3'(KIND_COUNT)) || (other >= 3'(KIND_COUNT))) begin
         return 1'b0;
      end
      return mask[idx];
   endfunction

endpackage

FILE: design/ropd_if.sv
// Channel interfaces of the rectangle overlap pair detector: request, response, register write.
interface ropd_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [15:0] rect_x;
   logic signed [15:0] rect_y;
   logic [14:0]        rect_w;
   logic [14:0]        rect_h;
   logic [2:0]         kind;
   logic               has_listener;
   logic               active_flag;
   logic [2:0]         slot;

   modport source (output valid, operation, rect_x, rect_y, rect_w, rect_h, kind,
                   has_listener, active_flag, slot, input ready);
   modport sink   (input valid, operation, rect_x, rect_y, rect_w, rect_h, kind,
                   has_listener, active_flag, slot, output ready);
endinterface

interface ropd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [2:0] slot_a;
   logic [2:0] slot_b;
   logic       notify_a;
   logic       notify_b;
   logic       last;

   modport source (output valid, result_kind, slot_a, slot_b, notify_a, notify_b, last,
                   input ready);
   modport sink   (input valid, result_kind, slot_a, slot_b, notify_a, notify_b, last,
                   output ready);
endinterface

interface ropd_csr_if;
   logic        valid;
   logic        ready;
   logic [24:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/ropd_datapath.sv
// Datapath: slot table memory, slot flags, pair evaluation and the response register.
module ropd_datapath import ropd_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic          clock,
   input  logic          reset,
   input  item_type      item,
   input  cmd_type       cmd,
   output sts_type       sts,
   ropd_rsp_if.source    rsp_ch,
   ropd_csr_if.sink      csr_ch
);

   localparam int SIDX_W = $clog2(SLOTS);

   // Slot table and read registers.
   entry_type slot_mem_ff [SLOTS];
   entry_type rd_a_ff, rd_b_ff;

   // Flag vectors and pair mask.
   logic [SLOTS-1:0]  used_ff, pend_ff, act_ff, lis_ff;
   logic [SLOTS-1:0]  used_in, pend_in, act_in, lis_in;
   logic [MASK_W-1:0] mask_ff;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_kind_ff, rsp_kind_in;
   logic [2:0] rsp_a_ff, rsp_a_in;
   logic [2:0] rsp_b_ff, rsp_b_in;
   logic       rsp_na_ff, rsp_na_in;
   logic       rsp_nb_ff, rsp_nb_in;
   logic       rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic [SIDX_W-1:0] free_idx;
   logic              table_full;
   logic [SIDX_W-1:0] tgt_idx;
   logic              tgt_hit;
   logic              add_wr;
   logic [SIDX_W-1:0] ev_a, ev_b;
   logic              ev_na, ev_nb;

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = SIDX_W'(i);
         end
      end
   end

   assign table_full = &used_ff;
   assign tgt_idx    = item.slot[SIDX_W-1:0];
   assign tgt_hit    = ({1'b0, item.slot} < 4'(SLOTS)) && used_ff[tgt_idx];
   assign add_wr     = cmd.exec && (item.operation == OP_ADD) && !table_full;

   // Pair evaluation on the registered table reads.
   assign ev_a  = cmd.ev_a[SIDX_W-1:0];
   assign ev_b  = cmd.ev_b[SIDX_W-1:0];
   assign ev_na = kind_allows(mask_ff, rd_a_ff.kind, rd_b_ff.kind) & lis_ff[ev_a] & act_ff[ev_a];
   assign ev_nb = kind_allows(mask_ff, rd_b_ff.kind, rd_a_ff.kind) & lis_ff[ev_b] & act_ff[ev_b];

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign sts.out_free = out_free;
   assign sts.pair_hit = used_ff[ev_a] && used_ff[ev_b] &&
                         entries_overlap(rd_a_ff, rd_b_ff) && (ev_na || ev_nb);

   // Flag updates for the single-result operations and the scan purge.
   always_comb begin
      used_in = used_ff;
      pend_in = pend_ff;
      act_in  = act_ff;
      lis_in  = lis_ff;
      if (cmd.purge) begin
         used_in = used_ff & ~pend_ff;
         act_in  = act_ff & used_in;
         lis_in  = lis_ff & used_in;
         pend_in = '0;
      end else if (cmd.exec) begin
         unique case (item.operation)
            OP_ADD: begin
               if (!table_full) begin
                  used_in[free_idx] = 1'b1;
                  pend_in[free_idx] = 1'b0;
                  act_in[free_idx]  = item.active_flag;
                  lis_in[free_idx]  = item.has_listener;
               end
            end
            OP_MARK: begin
               if (tgt_hit) begin
                  pend_in[tgt_idx] = 1'b1;
               end
            end
            OP_SETACT: begin
               if (tgt_hit) begin
                  act_in[tgt_idx] = item.active_flag;
               end
            end
            OP_CLEAR: begin
               used_in = '0;
               pend_in = '0;
               act_in  = '0;
               lis_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Next response contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_na_in    = rsp_na_ff;
      rsp_nb_in    = rsp_nb_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.exec || cmd.emit_pair || cmd.emit_done) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = RK_ACK;
         rsp_a_in     = 3'd0;
         rsp_b_in     = 3'd0;
         rsp_na_in    = 1'b0;
         rsp_nb_in    = 1'b0;
         rsp_last_in  = 1'b1;
         if (cmd.emit_pair) begin
            rsp_kind_in = RK_PAIR;
            rsp_a_in    = cmd.ev_a;
            rsp_b_in    = cmd.ev_b;
            rsp_na_in   = ev_na;
            rsp_nb_in   = ev_nb;
            rsp_last_in = 1'b0;
         end else if (cmd.emit_done) begin
            rsp_kind_in = RK_DONE;
         end else begin
            case (item.operation)
               OP_ADD: begin
                  rsp_kind_in = table_full ? RK_FULL : RK_ADDED;
                  rsp_a_in    = table_full ? 3'd0 : IDX_W'(free_idx);
               end
               OP_MARK, OP_SETACT: begin
                  rsp_a_in = item.slot;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         pend_ff      <= '0;
         act_ff       <= '0;
         lis_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         act_ff       <= act_in;
         lis_ff       <= lis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            mask_ff <= csr_ch.data;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_na_ff   <= rsp_na_in;
      rsp_nb_ff   <= rsp_nb_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Slot table: one write port for add, two registered read ports for the scan.
   always_ff @(posedge clock) begin
      if (add_wr) begin
         slot_mem_ff[free_idx] <= make_entry(item);
      end
      if (cmd.rd_en) begin
         rd_a_ff <= slot_mem_ff[cmd.rd_a[SIDX_W-1:0]];
         rd_b_ff <= slot_mem_ff[cmd.rd_b[SIDX_W-1:0]];
      end
   end

   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.slot_a      = rsp_a_ff;
   assign rsp_ch.slot_b      = rsp_b_ff;
   assign rsp_ch.notify_a    = rsp_na_ff;
   assign rsp_ch.notify_b    = rsp_nb_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

FILE: design/ropd_ctrl.sv
// Controller: accepts requests and sequences the scan over all slot pairs.
module ropd_ctrl import ropd_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam int SIDX_W = $clog2(SLOTS);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type         state_ff, state_in;
   logic [SIDX_W-1:0] ai_ff, ai_in, ak_ff, ak_in;
   logic [SIDX_W-1:0] ev_i_ff, ev_i_in, ev_k_ff, ev_k_in;
   logic              addr_vld_ff, addr_vld_in;
   logic              ev_vld_ff, ev_vld_in;

   logic accept, stall, last_pair;

   assign req_ready = (state_ff == S_IDLE) && sts.out_free;
   assign accept    = req_valid && req_ready;
   assign stall     = ev_vld_ff && sts.pair_hit && !sts.out_free;
   assign last_pair = (ai_ff == SIDX_W'(SLOTS - 2)) && (ak_ff == SIDX_W'(SLOTS - 1));

   // Commands to the datapath.
   always_comb begin
      cmd.exec      = accept && (req_op != OP_SCAN);
      cmd.purge     = accept && (req_op == OP_SCAN);
      cmd.rd_en     = (state_ff == S_SCAN) && !stall;
      cmd.rd_a      = IDX_W'(ai_ff);
      cmd.rd_b      = IDX_W'(ak_ff);
      cmd.ev_a      = IDX_W'(ev_i_ff);
      cmd.ev_b      = IDX_W'(ev_k_ff);
      cmd.emit_pair = (state_ff == S_SCAN) && ev_vld_ff && sts.pair_hit && sts.out_free;
      cmd.emit_done = (state_ff == S_DONE) && sts.out_free;
   end

   // Next state: one pair address issued and one pair evaluated per cycle while no stall holds the walk.
   always_comb begin
      state_in    = state_ff;
      ai_in       = ai_ff;
      ak_in       = ak_ff;
      ev_i_in     = ev_i_ff;
      ev_k_in     = ev_k_ff;
      addr_vld_in = addr_vld_ff;
      ev_vld_in   = ev_vld_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_SCAN)) begin
               state_in    = S_SCAN;
               ai_in       = '0;
               ak_in       = SIDX_W'(1);
               addr_vld_in = 1'b1;
               ev_vld_in   = 1'b0;
            end
         end
         S_SCAN: begin
            if (!addr_vld_ff && !ev_vld_ff) begin
               state_in = S_DONE;
            end else if (!stall) begin
               ev_vld_in = addr_vld_ff;
               ev_i_in   = ai_ff;
               ev_k_in   = ak_ff;
               if (addr_vld_ff) begin
                  if (last_pair) begin
                     addr_vld_in = 1'b0;
                  end else if (ak_ff == SIDX_W'(SLOTS - 1)) begin
                     ai_in = ai_ff + SIDX_W'(1);
                     ak_in = ai_ff + SIDX_W'(2);
                  end else begin
                     ak_in = ak_ff + SIDX_W'(1);
                  end
               end
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ai_ff       <= '0;
         ak_ff       <= '0;
         ev_i_ff     <= '0;
         ev_k_ff     <= '0;
         addr_vld_ff <= 1'b0;
         ev_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ai_ff       <= ai_in;
         ak_ff       <= ak_in;
         ev_i_ff     <= ev_i_in;
         ev_k_ff     <= ev_k_in;
         addr_vld_ff <= addr_vld_in;
         ev_vld_ff   <= ev_vld_in;
      end
   end

   // A result is only produced when the response register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pair || cmd.emit_done || cmd.exec) |-> sts.out_free)
      else $error("result issued while the response register is occupied");

   // An accepted scan request always starts the pair walk.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      cmd.purge |=> (state_ff == S_SCAN) && addr_vld_ff && !ev_vld_ff)
      else $error("scan did not start after its request");

   // A stalled evaluation keeps its pair.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && stall) |=> ($stable(ev_i_ff) && $stable(ev_k_ff) && ev_vld_ff))
      else $error("pair under evaluation changed during a stall");

   // The evaluated pair is always ordered lower slot first.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      ev_vld_ff |-> (ev_i_ff < ev_k_ff))
      else $error("pair evaluated out of order");

   // The done result is never issued with a pair still in flight.
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!ev_vld_ff && !addr_vld_ff))
      else $error("scan closed with pairs outstanding");

endmodule

FILE: design/rect_overlap_pair_detector.sv
// Top level of the rectangle overlap pair detector: controller and datapath.
//
//   Channel   Direction  Handshake        Transaction
//   req_ch    in         valid / ready    one operation (add, mark, set active, scan, clear)
//   rsp_ch    out        valid / ready    one result (added, full, ack, pair report, done)
//   csr_ch    in         valid / ready    write of the pair mask register
//
// Every operation except scan yields one result.
// A scan walks every slot pair; with an idle response side the pair walk reads two
// table entries per cycle and evaluates one pair per cycle.
// Back-pressure on rsp_ch stalls the walk on the pair that waits to be reported.
// Reset clears the slot flags and the pair mask; table entries are written by add.
module rect_overlap_pair_detector import ropd_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   ropd_req_if.sink   req_ch,
   ropd_rsp_if.source rsp_ch,
   ropd_csr_if.sink   csr_ch
);

   item_type item;
   cmd_type  cmd;
   sts_type  sts;

   // Request payload gathered into one item.
   assign item.operation    = req_ch.operation;
   assign item.rect_x       = req_ch.rect_x;
   assign item.rect_y       = req_ch.rect_y;
   assign item.rect_w       = req_ch.rect_w;
   assign item.rect_h       = req_ch.rect_h;
   assign item.kind         = req_ch.kind;
   assign item.has_listener = req_ch.has_listener;
   assign item.active_flag  = req_ch.active_flag;
   assign item.slot         = req_ch.slot;

   ropd_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_op    (req_ch.operation),
      .sts       (sts),
      .cmd       (cmd)
   );

   ropd_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .cmd    (cmd),
      .sts    (sts),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule
